// File: rtl/ccb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared types and character constants for the comment blanker.
// ----------------------------------------------------------------------------
package ccb_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        MODE_CODE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_BLOCK  = 2'd2,
        MODE_LINE   = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Work left by one request: the decided held byte and/or the final byte.
    typedef struct packed {
        logic       has_held;
        logic [7:0] held_byte;
        logic       has_last;
        logic [7:0] last_byte;
    } ccb_entry_t;

endpackage

// File: rtl/ccb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_front
// Accepts bytes, runs the scan-mode tracker with one byte of lookahead and
// queues the bytes that each request releases.
// ----------------------------------------------------------------------------
module ccb_front
    import ccb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   in_item,
    input  logic       q_full,
    output logic       q_push,
    output ccb_entry_t q_entry
);

    scan_mode_t mode_reg, mode_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] held_reg, held_next;
    logic       held_present_reg, held_present_next;

    scan_mode_t mode_dec;
    logic [7:0] cur_dec;
    logic [7:0] nxt_dec;
    logic       accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        mode_dec = mode_reg;
        cur_dec  = held_reg;
        nxt_dec  = in_item.in_byte;
        unique case (mode_reg)
            MODE_LINE:
            begin
                if (held_reg == CH_NL)
                    mode_dec = MODE_CODE;
                else
                    cur_dec = CH_SPACE;
            end
            MODE_BLOCK:
            begin
                if (held_reg == CH_STAR && in_item.in_byte == CH_SLASH
                    && prev_reg != CH_SLASH)
                begin
                    mode_dec = MODE_CODE;
                    nxt_dec  = CH_SPACE;
                end
                if (held_reg != CH_NL)
                    cur_dec = CH_SPACE;
            end
            MODE_STRING:
            begin
                if (held_reg == CH_DQUOTE && prev_reg != CH_BSLASH
                    && prev_reg != CH_APOS)
                    mode_dec = MODE_CODE;
            end
            default:
            begin
                if (held_reg == CH_DQUOTE)
                    mode_dec = MODE_STRING;
                else if (held_reg == CH_SLASH && in_item.in_byte == CH_SLASH)
                begin
                    mode_dec = MODE_LINE;
                    cur_dec  = CH_SPACE;
                    nxt_dec  = CH_SPACE;
                end
                else if (held_reg == CH_SLASH && in_item.in_byte == CH_STAR)
                begin
                    mode_dec = MODE_BLOCK;
                    cur_dec  = CH_SPACE;
                    nxt_dec  = CH_SPACE;
                end
            end
        endcase
    end

    always_comb
    begin
        mode_next         = mode_reg;
        prev_next         = prev_reg;
        held_next         = held_reg;
        held_present_next = held_present_reg;
        if (accept)
        begin
            if (in_item.in_last)
            begin
                // end of text: start over
                mode_next         = MODE_CODE;
                prev_next         = 8'h00;
                held_present_next = 1'b0;
            end
            else
            begin
                if (held_present_reg)
                begin
                    mode_next = mode_dec;
                    prev_next = cur_dec;
                    held_next = nxt_dec;
                end
                else
                    held_next = in_item.in_byte;
                held_present_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        q_push            = accept && (held_present_reg || in_item.in_last);
        q_entry.has_held  = held_present_reg;
        q_entry.held_byte = cur_dec;
        q_entry.has_last  = in_item.in_last;
        q_entry.last_byte = held_present_reg ? nxt_dec : in_item.in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_CODE;
            prev_reg         <= 8'h00;
            held_present_reg <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            prev_reg         <= prev_next;
            held_present_reg <= held_present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

// File: rtl/ccb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_fifo
// Short queue of work entries between the front and the back.
// ----------------------------------------------------------------------------
module ccb_fifo
    import ccb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  ccb_entry_t wr_entry,
    output logic       q_full,
    input  logic       rd_en,
    output ccb_entry_t rd_entry,
    output logic       q_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ccb_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_full   = (count_reg == CNT_W'(DEPTH));
    assign q_empty  = (count_reg == '0);
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_entry;
    end

endmodule

// File: rtl/ccb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_back
// Output stage: takes one queued entry at a time and presents its one or two
// result bytes on the output queue interface.
// ----------------------------------------------------------------------------
module ccb_back
    import ccb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ccb_entry_t rd_entry,
    input  logic       q_empty,
    output logic       rd_en,
    output logic       empty,
    input  logic       pop,
    output out_item_t  out_item
);

    logic       slot_valid_reg, slot_valid_next;
    logic       second_reg, second_next;
    ccb_entry_t slot_reg, slot_next;

    logic       show_held;
    logic       done;
    logic       load;

    assign show_held = !second_reg && slot_reg.has_held;
    assign empty     = !slot_valid_reg;

    always_comb
    begin
        out_item.out_byte = show_held ? slot_reg.held_byte : slot_reg.last_byte;
        out_item.out_last = !show_held;
    end

    // the slot is finished once its final byte is taken
    assign done  = pop && slot_valid_reg
                   && (second_reg || !(slot_reg.has_held && slot_reg.has_last));
    assign load  = !slot_valid_reg || done;
    assign rd_en = load && !q_empty;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        second_next     = second_reg;
        slot_next       = slot_reg;
        if (load)
        begin
            slot_valid_next = !q_empty;
            second_next     = 1'b0;
            slot_next       = rd_entry;
        end
        else if (pop && slot_valid_reg)
            second_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            second_reg     <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            second_reg     <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// File: rtl/c_comment_blanker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_blanker_core
// Replaces C block comments and C++ line comments in a byte stream by spaces.
//
// Input channel: push/full with in_item {in_byte, in_last}; a request is taken
// when push is high and full is low. Output channel: empty/pop with out_item
// {out_byte, out_last}; the oldest result is shown while empty is low and is
// taken when pop is high.
// Each byte is decided against the next one, so the output runs one byte
// behind the input: the first byte of a text gives no result unless it is
// also last; the byte flagged in_last releases two results (one if it is
// the only byte), the last with out_last set. Throughput: one input byte
// per cycle while full is low; the output stage drains one result per cycle
// while pop is high. A result is registered in the work queue and then in
// the output register before it appears on the output. When the receiver
// stalls, the work queue of FIFO_DEPTH entries fills and full is raised;
// nothing is dropped. Reset empties the queue and the output register and
// returns the scanner to plain code.
// ----------------------------------------------------------------------------
module c_comment_blanker_core
    import ccb_pkg::*;
#(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    ccb_entry_t q_wr_entry;
    ccb_entry_t q_rd_entry;

    ccb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_wr_entry)
    );

    ccb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_wr_entry),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_entry (q_rd_entry),
        .q_empty  (q_empty)
    );

    ccb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_entry (q_rd_entry),
        .q_empty  (q_empty),
        .rd_en    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for c_comment_blanker_core. Texts of C-like fragments
// (comments, strings, escapes, quotes, newlines, raw bytes) are pushed one
// byte per request; a scoreboard re-derives the blanked output with its own
// scanner and compares every popped result in order. Both sides idle at
// random, with one steady stretch in which the reader stalls long enough to
// fill the block.
// ----------------------------------------------------------------------------
module tb;
    import ccb_pkg::*;

    class blank_scoreboard;
        scan_mode_t mode;
        logic [7:0] last_out_char;
        logic [7:0] held_char;
        logic       held_valid;
        out_item_t  expected_chars[$];
        int         errors;

        function new();
            clear_text();
            errors = 0;
        endfunction

        function void clear_text();
            mode          = MODE_CODE;
            last_out_char = 8'h00;
            held_char     = 8'h00;
            held_valid    = 1'b0;
        endfunction

        // Decide one byte against its lookahead; both may turn into spaces.
        function void blank_pair(inout logic [7:0] cur, inout logic [7:0] nxt);
            case (mode)
                MODE_LINE:
                begin
                    if (cur == CH_NL)
                        mode = MODE_CODE;
                    else
                        cur = CH_SPACE;
                end
                MODE_BLOCK:
                begin
                    if (cur == CH_STAR && nxt == CH_SLASH && last_out_char != CH_SLASH)
                    begin
                        mode = MODE_CODE;
                        cur  = CH_SPACE;
                        nxt  = CH_SPACE;
                    end
                    if (cur != CH_NL)
                        cur = CH_SPACE;
                end
                MODE_STRING:
                begin
                    if (cur == CH_DQUOTE && last_out_char != CH_BSLASH
                        && last_out_char != CH_APOS)
                        mode = MODE_CODE;
                end
                default:
                begin
                    if (cur == CH_DQUOTE)
                        mode = MODE_STRING;
                    else if (cur == CH_SLASH && nxt == CH_SLASH)
                    begin
                        mode = MODE_LINE;
                        cur  = CH_SPACE;
                        nxt  = CH_SPACE;
                    end
                    else if (cur == CH_SLASH && nxt == CH_STAR)
                    begin
                        mode = MODE_BLOCK;
                        cur  = CH_SPACE;
                        nxt  = CH_SPACE;
                    end
                end
            endcase
            last_out_char = cur;
        endfunction

        function void note_request(in_item_t req);
            logic [7:0] cur;
            logic [7:0] nxt;
            out_item_t  res;
            nxt = req.in_byte;
            if (held_valid)
            begin
                cur = held_char;
                blank_pair(cur, nxt);
                res.out_byte = cur;
                res.out_last = 1'b0;
                expected_chars.push_back(res);
            end
            if (req.in_last)
            begin
                // flush the final byte, then start a fresh text
                res.out_byte = nxt;
                res.out_last = 1'b1;
                expected_chars.push_back(res);
                clear_text();
            end
            else
            begin
                held_char  = nxt;
                held_valid = 1'b1;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_chars.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: byte %h last %b", got.out_byte, got.out_last);
                return;
            end
            want = expected_chars.pop_front();
            if (got.out_byte !== want.out_byte || got.out_last !== want.out_last)
            begin
                errors++;
                if (errors <= 10)
                    $display("result differs: expected byte %h last %b, got byte %h last %b",
                             want.out_byte, want.out_last, got.out_byte, got.out_last);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;

    blank_scoreboard sb = new();
    logic [7:0]      text_bytes[$];
    int              sent;
    bit              steady;

    c_comment_blanker_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task send_request(input logic [7:0] b, input logic l);
        in_item_t req;
        in_item_t junk;
        req.in_byte = b;
        req.in_last = l;
        // idle at random outside the steady stretch, with junk on the payload
        while (!steady && $urandom_range(99) < 29)
        begin
            junk.in_byte = 8'($urandom_range(255));
            junk.in_last = 1'($urandom_range(1));
            push    <= 1'b0;
            in_item <= junk;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(req);
        sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], i == s.len() - 1);
    endtask

    task send_text_bytes();
        for (int i = 0; i < text_bytes.size(); i++)
            send_request(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    // Mostly well-formed C pieces, with loose delimiters and raw bytes mixed in.
    task add_fragment();
        string s;
        s = "";
        case ($urandom_range(0, 17))
            0:  s = "/*";
            1:  s = "*/";
            2:  s = "//";
            3:  s = "\"";
            4:  s = "\\\"";
            5:  s = "'\"'";
            6:  s = "\n";
            7:  s = "*";
            8:  s = "/";
            9:  s = "x = y;";
            10: s = "\\";
            11: s = "'";
            12: s = "/* a\n*/";
            13: s = "// z\n";
            14: s = "\"t/*\\\"\"";
            15: s = "a/b*c";
            default: text_bytes.push_back(8'($urandom_range(255)));
        endcase
        for (int i = 0; i < s.len(); i++)
            text_bytes.push_back(s[i]);
    endtask

    // Reader: random pops, one long hold-off once the steady stretch starts.
    initial
    begin
        int hold;
        bit long_hold_done;
        hold           = 0;
        long_hold_done = 1'b0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(out_item);
            if (steady && !long_hold_done)
            begin
                hold           = 300;
                long_hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else if (steady)
                pop <= 1'b1;
            else if ($urandom_range(99) < 29)
                pop <= 1'b0;
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        int frags;
        sent   = 0;
        steady = 1'b0;
        rst_n   <= 1'b0;
        push    <= 1'b0;
        in_item <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts
        send_request(8'hFF, 1'b1);
        send_text("//");
        send_text("a/*\n*/\"");
        send_text("\"\\\"/*\"");
        send_text("\"'\"a\"");
        send_request(8'h00, 1'b0);
        send_request(CH_SLASH, 1'b0);
        send_request(8'h00, 1'b1);

        // random texts
        while (sent < 1320)
        begin
            steady = (sent >= 500 && sent < 800);
            text_bytes.delete();
            if ($urandom_range(9) == 0)
                text_bytes.push_back(8'($urandom_range(255)));
            else
            begin
                frags = $urandom_range(1, 12);
                repeat (frags) add_fragment();
            end
            send_text_bytes();
        end
        steady = 1'b0;
        push <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
